// ===== src/controller_text_line_parser_macros.svh =====
// ---------------------------------------------------------------------------
// controller_text_line_parser_macros.svh
// Assertion macros used by the ctlp_emitter module of the controller text line parser.
// ---------------------------------------------------------------------------
`ifndef CONTROLLER_TEXT_LINE_PARSER_MACROS_SVH
`define CONTROLLER_TEXT_LINE_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CTLP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ctlp assertion failed");

// next-cycle implication
`define CTLP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ctlp assertion failed");

`endif

// ===== src/ctlp_pkg.sv =====
// ---------------------------------------------------------------------------
// ctlp_pkg
// Types, constants and key tables for the controller text line parser.
// ---------------------------------------------------------------------------
package ctlp_pkg;

	localparam int SEQ_WIDTH    = 32;
	localparam int BUTTON_WIDTH = 32;
	localparam int NFIELDS      = 18;
	localparam int HDR_LEN      = 16;

	// parser phases
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_KEY    = 2'd1;
	localparam logic [1:0] PH_VALUE  = 2'd2;

	// field codes
	localparam logic [4:0] FID_SLOT    = 5'd0;
	localparam logic [4:0] FID_SEQ     = 5'd1;
	localparam logic [4:0] FID_BUTTONS = 5'd2;
	localparam logic [4:0] FID_R2      = 5'd8;
	localparam logic [4:0] FID_TOUCH   = 5'd9;
	localparam logic [4:0] FID_TX      = 5'd10;
	localparam logic [4:0] FID_TY      = 5'd11;
	localparam logic [4:0] FID_GX      = 5'd12;
	localparam logic [4:0] FID_LAST    = 5'd17;
	localparam logic [4:0] FID_NONE    = 5'd31;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_NL    = 8'h0A;

	localparam logic [33:0] MOTION_MAX = 34'd1000000;

	typedef logic [NFIELDS-1:0][31:0] fstore_t;

	// line-done event from the parser to the emitter
	typedef struct packed {
		logic        valid;
		logic        ok;
		logic        motion;
		logic        wr_en;
		logic [4:0]  wr_id;
		logic [31:0] wr_val;
	} done_t;

	localparam logic [7:0] HDR_BYTES [HDR_LEN] = '{
		8'h42, 8'h41, 8'h43, 8'h48, 8'h41, 8'h54, 8'h41, 8'h2F,
		8'h31, 8'h20, 8'h49, 8'h4E, 8'h50, 8'h55, 8'h54, 8'h20
	};

	// key names packed low byte first
	localparam logic [55:0] KEY_NAME [NFIELDS] = '{
		56'h746f6c73, 56'h716573, 56'h736e6f74747562,
		56'h786c, 56'h796c, 56'h7872, 56'h7972, 56'h326c, 56'h3272,
		56'h6863756f74, 56'h7874, 56'h7974,
		56'h7867, 56'h7967, 56'h7a67, 56'h7861, 56'h7961, 56'h7a61
	};
	localparam logic [3:0] KEY_LEN [NFIELDS] = '{
		4'd4, 4'd3, 4'd7, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
		4'd5, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2
	};

	function automatic logic [4:0] classify_key(input logic [55:0] kb, input logic [3:0] kl);
		logic [4:0] id;
		id = FID_NONE;
		for (int i = 0; i < NFIELDS; i++) begin
			if (kl == KEY_LEN[i] && kb == KEY_NAME[i])
				id = 5'(i);
		end
		return id;
	endfunction

	// upper bound of the unsigned fields
	function automatic logic [33:0] field_hi(input logic [4:0] id);
		logic [33:0] hi;
		case (id)
			FID_SLOT:    hi = 34'd3;
			FID_SEQ:     hi = (34'd1 << SEQ_WIDTH) - 34'd1;
			FID_BUTTONS: hi = (34'd1 << BUTTON_WIDTH) - 34'd1;
			FID_TOUCH:   hi = 34'd1;
			FID_TX:      hi = 34'd1919;
			FID_TY:      hi = 34'd1079;
			default:     hi = 34'd255;
		endcase
		return hi;
	endfunction

endpackage

// ===== src/ctlp_parser.sv =====
// ---------------------------------------------------------------------------
// ctlp_parser
// Input register and per-byte parser: header match, key capture, value
// accumulation, range and duplicate checks, field store.
// ---------------------------------------------------------------------------
module ctlp_parser import ctlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	input  logic       line_end,
	input  logic       emit_busy,
	output done_t      done,
	output fstore_t    store
);

	logic        v_s1, end_s1;
	logic [7:0]  byte_s1;
	logic        fire;

	logic [1:0]  phase_q, phase_d;
	logic [4:0]  hpos_q, hpos_d;
	logic [55:0] kbuf_q, kbuf_d;
	logic [3:0]  klen_q, klen_d;
	logic [33:0] acc_q, acc_d;
	logic        neg_q, neg_d, hex_q, hex_d, dig_q, dig_d, ovf_q, ovf_d;
	logic        aspc_q, aspc_d;
	logic        err_q, err_d;
	logic [11:0] seen_q, seen_d;
	logic [5:0]  mseen_q, mseen_d;
	fstore_t     store_q;

	// finish-value results
	logic [4:0]  vid;
	logic [33:0] hi;
	logic        rng_ok, dup, fin_err;
	logic [31:0] fin_val;
	logic [11:0] seen_f;
	logic [5:0]  mseen_f;

	// digit step
	logic        is_dig, is_hexl, is_hexu, dig_ok;
	logic [3:0]  dval;
	logic [37:0] nacc;

	logic        end_err;
	logic [11:0] seen_e;
	logic [5:0]  mseen_e;
	logic [4:0]  cls;

	assign fire     = v_s1 && !(end_s1 && emit_busy);
	assign in_ready = !v_s1 || fire;
	assign store    = store_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= byte_in;
			end_s1  <= line_end;
		end
	end

	// value completion checks
	always_comb begin
		vid     = kbuf_q[4:0];
		hi      = field_hi(vid);
		if (vid >= FID_GX)
			rng_ok = acc_q <= MOTION_MAX;
		else
			rng_ok = neg_q ? (acc_q == 34'd0) : (acc_q <= hi);
		dup     = (vid >= FID_GX) ? mseen_q[3'(vid - FID_GX)] : seen_q[vid[3:0]];
		fin_err = !dig_q || ovf_q || vid > FID_LAST || !rng_ok || dup;
		fin_val = neg_q ? (32'd0 - acc_q[31:0]) : acc_q[31:0];
		seen_f  = seen_q;
		mseen_f = mseen_q;
		if (!fin_err) begin
			if (vid >= FID_GX)
				mseen_f[3'(vid - FID_GX)] = 1'b1;
			else
				seen_f[vid[3:0]] = 1'b1;
		end
	end

	// digit decode and accumulate
	always_comb begin
		is_dig  = byte_s1 >= 8'h30 && byte_s1 <= 8'h39;
		is_hexl = byte_s1 >= 8'h61 && byte_s1 <= 8'h66;
		is_hexu = byte_s1 >= 8'h41 && byte_s1 <= 8'h46;
		dig_ok  = is_dig || (hex_q && (is_hexl || is_hexu));
		if (is_dig)
			dval = 4'(byte_s1 - 8'h30);
		else if (is_hexl)
			dval = 4'(byte_s1 - 8'h57);
		else
			dval = 4'(byte_s1 - 8'h37);
		if (hex_q)
			nacc = {acc_q, 4'b0} + 38'(dval);
		else
			nacc = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + 38'(dval);
	end

	assign cls = classify_key(kbuf_q, klen_q);

	// next state for an ordinary byte
	always_comb begin
		phase_d = phase_q;
		hpos_d  = hpos_q;
		kbuf_d  = kbuf_q;
		klen_d  = klen_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		hex_d   = hex_q;
		dig_d   = dig_q;
		ovf_d   = ovf_q;
		aspc_d  = aspc_q;
		err_d   = err_q;
		seen_d  = seen_q;
		mseen_d = mseen_q;
		case (phase_q)
			PH_HEADER: begin
				if (byte_s1 != HDR_BYTES[hpos_q[3:0]]) begin
					err_d = 1'b1;
				end else begin
					hpos_d = hpos_q + 5'd1;
					if (hpos_q == 5'(HDR_LEN - 1))
						phase_d = PH_KEY;
				end
			end
			PH_KEY: begin
				if (byte_s1 == CH_SPACE) begin
					err_d = 1'b1;
				end else if (byte_s1 == CH_EQ) begin
					if (klen_q == 4'd0 || cls == FID_NONE) begin
						err_d = 1'b1;
					end else begin
						kbuf_d  = 56'(cls);
						klen_d  = 4'd0;
						acc_d   = 34'd0;
						{neg_d, hex_d, dig_d, ovf_d} = 4'b0;
						phase_d = PH_VALUE;
					end
				end else begin
					aspc_d = 1'b0;
					if (klen_q < 4'd7) begin
						kbuf_d = kbuf_q | (56'(byte_s1) << {klen_q[2:0], 3'b0});
						klen_d = klen_q + 4'd1;
					end else begin
						klen_d = 4'd8;
					end
				end
			end
			default: begin
				if (byte_s1 == CH_SPACE) begin
					if (fin_err) begin
						err_d = 1'b1;
					end else begin
						seen_d  = seen_f;
						mseen_d = mseen_f;
					end
					aspc_d  = 1'b1;
					phase_d = PH_KEY;
					klen_d  = 4'd0;
					kbuf_d  = 56'd0;
				end else if (byte_s1 == CH_MINUS) begin
					if (klen_q == 4'd0 && vid != FID_SEQ && vid != FID_BUTTONS) begin
						neg_d  = 1'b1;
						klen_d = 4'd1;
					end else begin
						err_d = 1'b1;
					end
				end else if (byte_s1 == CH_X) begin
					if (vid == FID_BUTTONS && klen_q == 4'd1 && dig_q && !neg_q && !hex_q
							&& !ovf_q && acc_q == 34'd0) begin
						hex_d  = 1'b1;
						dig_d  = 1'b0;
						klen_d = 4'd2;
					end else begin
						err_d = 1'b1;
					end
				end else if (dig_ok) begin
					if (!ovf_q) begin
						acc_d = nacc[33:0];
						if (|nacc[37:33])
							ovf_d = 1'b1;
					end
					dig_d = 1'b1;
					if (klen_q < 4'd15)
						klen_d = klen_q + 4'd1;
				end else begin
					err_d = 1'b1;
				end
			end
		endcase
	end

	// line end verdict
	always_comb begin
		seen_e  = seen_q;
		mseen_e = mseen_q;
		end_err = err_q || byte_s1 != CH_NL || phase_q == PH_HEADER;
		if (phase_q == PH_KEY) begin
			if (klen_q != 4'd0 || aspc_q)
				end_err = 1'b1;
		end else if (phase_q == PH_VALUE) begin
			end_err = end_err || fin_err;
			seen_e  = seen_f;
			mseen_e = mseen_f;
		end
		if (seen_e != 12'hFFF && seen_e != 12'hFFE)
			end_err = 1'b1;
		if (mseen_e != 6'h00 && mseen_e != 6'h3F)
			end_err = 1'b1;
	end

	always_comb begin
		done.valid  = fire && end_s1;
		done.ok     = !end_err;
		done.motion = mseen_e == 6'h3F;
		done.wr_en  = phase_q == PH_VALUE;
		done.wr_id  = vid;
		done.wr_val = fin_val;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hpos_q  <= '0;
			kbuf_q  <= '0;
			klen_q  <= '0;
			acc_q   <= '0;
			{neg_q, hex_q, dig_q, ovf_q} <= '0;
			aspc_q  <= 1'b0;
			err_q   <= 1'b0;
			seen_q  <= '0;
			mseen_q <= '0;
			store_q <= '0;
		end else if (fire && end_s1) begin
			phase_q <= PH_HEADER;
			hpos_q  <= '0;
			kbuf_q  <= '0;
			klen_q  <= '0;
			acc_q   <= '0;
			{neg_q, hex_q, dig_q, ovf_q} <= '0;
			aspc_q  <= 1'b0;
			err_q   <= 1'b0;
			seen_q  <= '0;
			mseen_q <= '0;
			store_q <= '0;
		end else if (fire && !err_q) begin
			phase_q <= phase_d;
			hpos_q  <= hpos_d;
			kbuf_q  <= kbuf_d;
			klen_q  <= klen_d;
			acc_q   <= acc_d;
			{neg_q, hex_q, dig_q, ovf_q} <= {neg_d, hex_d, dig_d, ovf_d};
			aspc_q  <= aspc_d;
			err_q   <= err_d;
			seen_q  <= seen_d;
			mseen_q <= mseen_d;
			if (phase_q == PH_VALUE && byte_s1 == CH_SPACE && !fin_err)
				store_q[vid] <= fin_val;
		end
	end

endmodule

// ===== src/ctlp_emitter.sv =====
// ---------------------------------------------------------------------------
// ctlp_emitter
// Captures a finished line and hands out its results one item per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module ctlp_emitter import ctlp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  done_t        done,
	input  fstore_t      store,
	output logic         busy,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [4:0]   field_id,
	output logic [32:0]  field_value,
	output logic         line_ok,
	output logic         last_of_line
);

`include "controller_text_line_parser_macros.svh"

	fstore_t    buf_q;
	fstore_t    snap;
	logic       busy_q, ok_q;
	logic [4:0] idx_q, last_q;
	logic [31:0] cur;

	assign busy         = busy_q;
	assign out_valid    = busy_q;
	assign field_id     = idx_q;
	assign line_ok      = ok_q;
	assign last_of_line = idx_q == last_q;
	assign cur          = buf_q[idx_q];

	// motion fields are signed, the rest unsigned
	always_comb begin
		if (!ok_q)
			field_value = 33'd0;
		else if (idx_q >= FID_GX)
			field_value = {cur[31], cur};
		else
			field_value = {1'b0, cur};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ok_q   <= 1'b0;
			idx_q  <= '0;
			last_q <= '0;
		end else if (done.valid) begin
			busy_q <= 1'b1;
			ok_q   <= done.ok;
			idx_q  <= '0;
			if (!done.ok)
				last_q <= FID_SLOT;
			else if (done.motion)
				last_q <= FID_LAST;
			else
				last_q <= FID_TY;
		end else if (busy_q && out_ready) begin
			if (idx_q == last_q)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 5'd1;
		end
	end

	// line's fields with the final value merged in
	always_comb begin
		snap = store;
		if (done.wr_en && done.wr_id <= FID_LAST)
			snap[done.wr_id] = done.wr_val;
	end

	// snapshot taken at the line end
	always_ff @(posedge clk) begin
		if (done.valid) begin
			buf_q <= snap;
		end
	end

	`CTLP_ASSERT_IMP(a_load_idle, done.valid, !busy_q)
	`CTLP_ASSERT_IMP(a_reject_single, busy_q && !ok_q, idx_q == FID_SLOT && last_of_line)
	`CTLP_ASSERT_IMP(a_last_bound, busy_q, last_q == FID_SLOT || last_q == FID_TY || last_q == FID_LAST)
	`CTLP_ASSERT_NXT(a_run_continues, busy_q && out_ready && !last_of_line, busy_q)

endmodule

// ===== src/controller_text_line_parser.sv =====
// ---------------------------------------------------------------------------
// controller_text_line_parser
// Byte-wide parser for one controller-state text line, emitting its fields.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle, except while a line end waits for the emitter.
// The emitter registers a line as its newline leaves the input register, then
// emits one result per out_ready cycle (12 or 18 per good line, 1 per reject).
// A line end waits in the input register while the previous line still drains.
// Reset (arst_n low) clears all line state; results appear only after a line end.
module controller_text_line_parser import ctlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  field_id,
	output logic [32:0] field_value,
	output logic        line_ok,
	output logic        last_of_line
);

	done_t   done;
	fstore_t store;
	logic    busy;

	ctlp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.byte_in   (byte_in),
		.line_end  (line_end),
		.emit_busy (busy),
		.done      (done),
		.store     (store)
	);

	ctlp_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.done         (done),
		.store        (store),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.field_id     (field_id),
		.field_value  (field_value),
		.line_ok      (line_ok),
		.last_of_line (last_of_line)
	);

endmodule

// ===== dv/ctlp_checker.sv =====
// ---------------------------------------------------------------------------
// ctlp_checker
// Watches both channels of the controller text line parser. Each byte taken
// in steps a line parser of its own; at a line end the expected fields (or
// the reject) are queued, and every result the block hands out is compared
// field by field with the oldest one waiting.
// ---------------------------------------------------------------------------
module ctlp_checker import ctlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        line_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  field_id,
	input  logic [32:0] field_value,
	input  logic        line_ok,
	input  logic        last_of_line,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {ST_HDR, ST_KEY, ST_VAL} pstate_e;

	typedef struct {
		logic [4:0]  id;
		logic [32:0] value;
		logic        ok;
		logic        last;
	} field_res_t;

	field_res_t fields_due[$];

	string key_txt [NFIELDS] = '{"slot", "seq", "buttons", "lx", "ly", "rx", "ry",
		"l2", "r2", "touch", "tx", "ty", "gx", "gy", "gz", "ax", "ay", "az"};

	pstate_e         st;
	int              hpos, klen;
	logic [55:0]     kbuf;
	longint unsigned acc;
	bit              f_neg, f_hex, f_dig, f_ovf;
	bit              after_sp, bad;
	logic [11:0]     seen;
	logic [5:0]      mseen;
	logic [31:0]     vals [NFIELDS];

	assign pending = fields_due.size();

	task automatic clear_line();
		st = ST_HDR; hpos = 0; klen = 0; kbuf = '0; acc = 0;
		{f_neg, f_hex, f_dig, f_ovf} = '0;
		after_sp = 0; bad = 0; seen = '0; mseen = '0;
		foreach (vals[i]) vals[i] = '0;
	endtask

	// key text to field code, 31 when unknown
	function automatic int key_code();
		logic [55:0] p;
		int r;
		r = 31;
		if (klen <= 7) begin
			foreach (key_txt[k]) begin
				p = '0;
				for (int i = 0; i < key_txt[k].len(); i++)
					p[8*i +: 8] = key_txt[k][i];
				if (key_txt[k].len() == klen && p == kbuf)
					r = k;
			end
		end
		return r;
	endfunction

	task automatic close_value();
		int id;
		longint v, lo, hi;
		id = int'(kbuf[4:0]);
		lo = 0;
		if (bad) return;
		if (!f_dig || f_ovf || id >= NFIELDS) begin
			bad = 1;
			return;
		end
		v = longint'(acc);
		if (f_neg) v = -v;
		if (id == 0) hi = 3;
		else if (id == 1) hi = (64'd1 << SEQ_WIDTH) - 1;
		else if (id == 2) hi = (64'd1 << BUTTON_WIDTH) - 1;
		else if (id <= 8) hi = 255;
		else if (id == 9) hi = 1;
		else if (id == 10) hi = 1919;
		else if (id == 11) hi = 1079;
		else begin
			lo = -1000000;
			hi = 1000000;
		end
		if (v < lo || v > hi) begin
			bad = 1;
			return;
		end
		if (id < 12) begin
			if (seen[id]) begin bad = 1; return; end
			seen[id] = 1;
		end else begin
			if (mseen[id-12]) begin bad = 1; return; end
			mseen[id-12] = 1;
		end
		vals[id] = v[31:0];
	endtask

	task automatic value_byte(input logic [7:0] c);
		int id, d;
		id = int'(kbuf[4:0]);
		if (c == "-") begin
			if (klen == 0 && id != 1 && id != 2) begin
				f_neg = 1;
				klen = 1;
			end else bad = 1;
			return;
		end
		if (c == "x") begin
			if (id == 2 && klen == 1 && f_dig && !f_neg && !f_hex && !f_ovf && acc == 0) begin
				{f_neg, f_dig, f_ovf} = '0;
				f_hex = 1;
				klen = 2;
			end else bad = 1;
			return;
		end
		if (c >= "0" && c <= "9") d = c - "0";
		else if (f_hex && c >= "a" && c <= "f") d = c - "a" + 10;
		else if (f_hex && c >= "A" && c <= "F") d = c - "A" + 10;
		else begin
			bad = 1;
			return;
		end
		if (!f_ovf) begin
			acc = acc * (f_hex ? 16 : 10) + d;
			if (acc >= 64'h2_0000_0000) f_ovf = 1;
		end
		f_dig = 1;
		if (klen < 15) klen++;
	endtask

	task automatic line_byte(input logic [7:0] c);
		int id;
		case (st)
			ST_HDR: begin
				if (hpos >= HDR_LEN || c != HDR_BYTES[hpos]) begin
					bad = 1;
					return;
				end
				hpos++;
				if (hpos == HDR_LEN) st = ST_KEY;
			end
			ST_KEY: begin
				if (c == " ") bad = 1;
				else if (c == "=") begin
					if (klen == 0) begin bad = 1; return; end
					id = key_code();
					if (id == 31) begin bad = 1; return; end
					kbuf = 56'(id);
					klen = 0; acc = 0;
					{f_neg, f_hex, f_dig, f_ovf} = '0;
					st = ST_VAL;
				end else begin
					after_sp = 0;
					if (klen < 7) begin
						kbuf[8*klen +: 8] = c;
						klen++;
					end else klen = 8;
				end
			end
			default: begin
				if (c == " ") begin
					close_value();
					after_sp = 1;
					st = ST_KEY;
					klen = 0;
					kbuf = '0;
				end else value_byte(c);
			end
		endcase
	endtask

	// line end: queue the reject or the run of fields
	task automatic close_line(input logic [7:0] c);
		int total;
		logic [32:0] v;
		if (c != 8'h0A || st == ST_HDR) bad = 1;
		if (!bad) begin
			if (st == ST_KEY) begin
				if (klen != 0 || after_sp) bad = 1;
			end else close_value();
		end
		if (!bad) begin
			if (seen != 12'hFFF && seen != 12'hFFE) bad = 1;
			if (mseen != 6'h00 && mseen != 6'h3F) bad = 1;
		end
		if (bad) fields_due.push_back('{5'd0, 33'd0, 1'b0, 1'b1});
		else begin
			total = (mseen == 6'h3F) ? NFIELDS : 12;
			for (int i = 0; i < total; i++) begin
				if (i >= 12) v = {vals[i][31], vals[i]};
				else v = {1'b0, vals[i]};
				if (i == 0 && !seen[0]) v = '0;
				fields_due.push_back('{5'(i), v, 1'b1, i == total - 1});
			end
		end
		clear_line();
	endtask

	always @(posedge clk) begin
		field_res_t e;
		if (!arst_n) begin
			errors = 0;
			clear_line();
			fields_due.delete();
		end else begin
			if (in_valid && in_ready) begin
				if (!line_end) begin
					if (!bad) line_byte(byte_in);
				end else close_line(byte_in);
			end
			if (out_valid && out_ready) begin
				if (fields_due.size() == 0) begin
					errors++;
					$display("%0t: expected no result, actual id %0d value %0d", $time,
						field_id, $signed(field_value));
				end else begin
					e = fields_due.pop_front();
					if (field_id !== e.id || field_value !== e.value ||
					    line_ok !== e.ok || last_of_line !== e.last) begin
						errors++;
						$display("%0t: expected id %0d val %0d ok %0b last %0b", $time,
							e.id, $signed(e.value), e.ok, e.last);
						$display("%0t:   actual id %0d val %0d ok %0b last %0b", $time,
							field_id, $signed(field_value), line_ok, last_of_line);
					end
				end
			end
		end
	end
endmodule

// ===== dv/tb_controller_text_line_parser.sv =====
// ---------------------------------------------------------------------------
// tb_controller_text_line_parser
// Feeds text lines byte by byte: a directed good line with every field and
// an empty one, then short broken lines and noise. Idling on both sides
// changes phase as the run goes; the checker beside the block does all
// prediction and comparison.
// ---------------------------------------------------------------------------
module tb_controller_text_line_parser;
	import ctlp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n;
	logic        in_valid, in_ready, line_end, out_valid, out_ready;
	logic [7:0]  byte_in;
	logic [4:0]  field_id;
	logic [32:0] field_value;
	logic        line_ok, last_of_line;
	int          errors, pending;

	int          send_idle, recv_stall, quiet;
	logic        hold_out, hold_go;
	logic [7:0]  line_q[$];

	controller_text_line_parser u_dut (.*);

	ctlp_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			out_ready <= !hold_out && ($urandom_range(99) >= recv_stall);
		end
	end

	initial begin
		hold_out = 0;
		@(posedge hold_go);
		hold_out <= 1;
		repeat (400) @(posedge clk);
		hold_out <= 0;
	end

	// watchdog on cycles with no item moving either way
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else if (quiet >= 5000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else quiet <= quiet + 1;
	end

	task automatic put_byte(input logic [7:0] b, input logic e);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		byte_in  <= b;
		line_end <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_line();
		foreach (line_q[i]) put_byte(line_q[i], i == line_q.size() - 1);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
	endtask

	task automatic send_text(input bit hdr, input string body);
		line_q = {};
		if (hdr) foreach (HDR_BYTES[i]) line_q.push_back(HDR_BYTES[i]);
		add_text(body);
		line_q.push_back(8'h0A);
		send_line();
	endtask

	task automatic noise_line();
		line_q = {};
		repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom));
		send_line();
	endtask

	initial begin
		string good;
		arst_n = 0; in_valid = 0; byte_in = '0; line_end = 0;
		send_idle = 0; recv_stall = 0; hold_go = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed lines: every field with extremes, then an empty body
		good = {"slot=3 seq=4294967295 buttons=0xfF lx=255 ly=0 rx=1 ry=2 l2=3 r2=4 ",
		        "touch=1 tx=1919 ty=1079 gx=1000000 gy=-1000000 gz=-0 ax=0 ay=-1 az=42"};
		send_text(1, good);
		send_text(1, "");

		// short lines through the idling phases
		for (int ln = 0; ln < 12; ln++) begin
			case (ln / 3)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 80; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 80; end
				default: begin send_idle = 14; recv_stall = 14; end
			endcase
			if (ln == 6) hold_go <= 1;
			if (ln == 9) begin
				in_valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (ln % 2 == 0) noise_line();
			else begin
				line_q = {HDR_BYTES[0], HDR_BYTES[1]};
				send_line();
			end
		end
		in_valid <= 0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/ctlp_pkg.sv
src/ctlp_parser.sv
src/ctlp_emitter.sv
src/controller_text_line_parser.sv
dv/ctlp_checker.sv
dv/tb_controller_text_line_parser.sv
